/* rtl/ism_pkg.sv */
// Shared types and constants for the interval set membership table.
// Used by ism_cell and the top level; no dependencies.
package ism_pkg;

    localparam int VALUE_W        = 64;
    localparam int FUNC_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int RCOUNT_W       = 7;
    localparam int MAX_RANGES_DEF = 64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_TEST   = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_CHANGED   = 2'd0,
        STAT_NO_CHANGE = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    // Update applied by every cell in the update cycle
    typedef enum logic [3:0] {
        MODE_NONE,
        MODE_ADD_NEW,
        MODE_ADD_LO,
        MODE_ADD_HI,
        MODE_ADD_BOTH,
        MODE_REM_DEL,
        MODE_REM_LEFT,
        MODE_REM_RIGHT,
        MODE_REM_SPLIT
    } mode_t;

    typedef struct packed {
        logic hit;     // range holds the value
        logic lo;      // range ends right at the value
        logic hi;      // range starts right after the value
        logic gt;      // range lies wholly above the value
        logic hleft;   // holding range keeps a part below the value
        logic hright;  // holding range keeps a part above the value
    } cell_flags_t;

    typedef struct packed {
        logic  cmp_en;
        mode_t mode;
    } cell_ctrl_t;

endpackage

/* rtl/interval_set_membership_table_top.sv */
// Top level of the interval set membership table: request control, counters
// and the row of ism_cell slots. Depends on ism_pkg and ism_cell.
//
// Usage:
//   A request (func, value) is taken at a rising edge with start high and
//   busy low. func selects add, remove or test; func 3 acts as a test.
//   The result (found, status, member_count, range_count, is_empty) is shown
//   for exactly one cycle with done high, after the request's compare and
//   update cycles. The receiver cannot stall the block; results must be taken
//   as they come.
// Request flow:
//   A request passes through a compare cycle, in which every slot checks its
//   range against the value at once, and an update cycle, in which the slots
//   merge, split or shift by one place with their neighbors. busy is high
//   only in the compare cycle, so a new request can be taken in the update
//   cycle of the one before it. The compare flags are registered before any
//   slot may move.
// Reset:
//   rst_n clears the table to empty, member and range counts to zero and
//   drops done; no clearing pass is needed.
module interval_set_membership_table_top #(
    parameter int MAX_RANGES = ism_pkg::MAX_RANGES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ism_pkg::FUNC_W-1:0]       func,
    input  logic [ism_pkg::VALUE_W-1:0]      value,
    output logic                             done,
    output logic                             found,
    output logic [ism_pkg::STATUS_W-1:0]     status,
    output logic [ism_pkg::VALUE_W-1:0]      member_count,
    output logic [ism_pkg::RCOUNT_W-1:0]     range_count,
    output logic                             is_empty
);

    localparam int CNT_W = $clog2(MAX_RANGES + 1);

    ism_pkg::state_t              state_reg, state_next;
    logic [ism_pkg::FUNC_W-1:0]   func_reg;
    logic [ism_pkg::VALUE_W-1:0]  value_reg;
    logic [CNT_W-1:0]             held_reg, held_next;
    logic [ism_pkg::VALUE_W-1:0]  members_reg, members_next;
    logic                         done_reg;
    logic                         found_reg;
    ism_pkg::status_t             status_reg, status_next;
    ism_pkg::cell_ctrl_t          ctrl;
    ism_pkg::mode_t               mode;
    logic                         accept;

    logic [ism_pkg::VALUE_W-1:0]  cell_start [MAX_RANGES];
    logic [ism_pkg::VALUE_W-1:0]  cell_stop  [MAX_RANGES];
    logic                         cell_used  [MAX_RANGES];
    ism_pkg::cell_flags_t         cell_flags [MAX_RANGES];

    logic [MAX_RANGES-1:0]        hit_vec, lo_vec, hi_vec, hleft_vec, hright_vec;
    logic                         any_hit, any_lo, any_hi, any_hleft, any_hright;
    logic                         table_full;

    // request FSM: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ism_pkg::ST_IDLE: if (start) state_next = ism_pkg::ST_CMP;
            ism_pkg::ST_CMP:  state_next = ism_pkg::ST_UPD;
            ism_pkg::ST_UPD:  state_next = start ? ism_pkg::ST_CMP : ism_pkg::ST_IDLE;
            default:          state_next = ism_pkg::ST_IDLE;
        endcase
    end

    // request FSM: outputs
    always_comb
    begin
        busy        = 1'b0;
        ctrl.cmp_en = 1'b0;
        ctrl.mode   = ism_pkg::MODE_NONE;
        case (state_reg)
            ism_pkg::ST_CMP:
            begin
                busy        = 1'b1;
                ctrl.cmp_en = 1'b1;
            end
            ism_pkg::ST_UPD:  ctrl.mode = mode;
            default:          ctrl.mode = ism_pkg::MODE_NONE;
        endcase
    end

    assign accept = start && !busy;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RANGES; gi++)
        begin : g_cell
            logic [ism_pkg::VALUE_W-1:0] p_start, p_stop, n_start, n_stop;
            logic                        p_used, n_used;
            ism_pkg::cell_flags_t        p_flags;

            if (gi == 0)
            begin : g_first
                // slot 0 sees a used, non-matching neighbor below it
                assign p_start = '0;
                assign p_stop  = '0;
                assign p_used  = 1'b1;
                assign p_flags = '0;
            end
            else
            begin : g_mid
                assign p_start = cell_start[gi-1];
                assign p_stop  = cell_stop[gi-1];
                assign p_used  = cell_used[gi-1];
                assign p_flags = cell_flags[gi-1];
            end

            if (gi == MAX_RANGES - 1)
            begin : g_last
                assign n_start = '0;
                assign n_stop  = '0;
                assign n_used  = 1'b0;
            end
            else
            begin : g_body
                assign n_start = cell_start[gi+1];
                assign n_stop  = cell_stop[gi+1];
                assign n_used  = cell_used[gi+1];
            end

            ism_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .value      (value_reg),
                .prev_start (p_start),
                .prev_stop  (p_stop),
                .prev_used  (p_used),
                .prev_flags (p_flags),
                .next_start (n_start),
                .next_stop  (n_stop),
                .next_used  (n_used),
                .start      (cell_start[gi]),
                .stop       (cell_stop[gi]),
                .used       (cell_used[gi]),
                .flags      (cell_flags[gi])
            );

            assign hit_vec[gi]    = cell_flags[gi].hit;
            assign lo_vec[gi]     = cell_flags[gi].lo;
            assign hi_vec[gi]     = cell_flags[gi].hi;
            assign hleft_vec[gi]  = cell_flags[gi].hleft;
            assign hright_vec[gi] = cell_flags[gi].hright;
        end
    endgenerate

    assign any_hit    = |hit_vec;
    assign any_lo     = |lo_vec;
    assign any_hi     = |hi_vec;
    assign any_hleft  = |hleft_vec;
    assign any_hright = |hright_vec;
    assign table_full = (held_reg == CNT_W'(MAX_RANGES));

    // pick the update from the compare flags
    always_comb
    begin
        mode         = ism_pkg::MODE_NONE;
        status_next  = ism_pkg::STAT_NO_CHANGE;
        held_next    = held_reg;
        members_next = members_reg;
        case (func_reg)
            ism_pkg::FUNC_ADD:
            begin
                if (!any_hit)
                begin
                    status_next  = ism_pkg::STAT_CHANGED;
                    members_next = members_reg + ism_pkg::VALUE_W'(1);
                    if (any_lo && any_hi)
                    begin
                        mode      = ism_pkg::MODE_ADD_BOTH;
                        held_next = held_reg - CNT_W'(1);
                    end
                    else if (any_lo)
                        mode = ism_pkg::MODE_ADD_LO;
                    else if (any_hi)
                        mode = ism_pkg::MODE_ADD_HI;
                    else if (table_full)
                    begin
                        status_next  = ism_pkg::STAT_FULL;
                        members_next = members_reg;
                    end
                    else
                    begin
                        mode      = ism_pkg::MODE_ADD_NEW;
                        held_next = held_reg + CNT_W'(1);
                    end
                end
            end
            ism_pkg::FUNC_REMOVE:
            begin
                if (any_hit)
                begin
                    status_next  = ism_pkg::STAT_CHANGED;
                    members_next = members_reg - ism_pkg::VALUE_W'(1);
                    if (any_hleft && any_hright)
                    begin
                        if (table_full)
                        begin
                            status_next  = ism_pkg::STAT_FULL;
                            members_next = members_reg;
                        end
                        else
                        begin
                            mode      = ism_pkg::MODE_REM_SPLIT;
                            held_next = held_reg + CNT_W'(1);
                        end
                    end
                    else if (any_hleft)
                        mode = ism_pkg::MODE_REM_LEFT;
                    else if (any_hright)
                        mode = ism_pkg::MODE_REM_RIGHT;
                    else
                    begin
                        mode      = ism_pkg::MODE_REM_DEL;
                        held_next = held_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                status_next = ism_pkg::STAT_NO_CHANGE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ism_pkg::ST_IDLE;
            held_reg    <= '0;
            members_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ism_pkg::ST_UPD);
            if (state_reg == ism_pkg::ST_UPD)
            begin
                held_reg    <= held_next;
                members_reg <= members_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            value_reg <= value;
        end
        if (state_reg == ism_pkg::ST_UPD)
        begin
            found_reg  <= any_hit;
            status_reg <= status_next;
        end
    end

    assign done         = done_reg;
    assign found        = found_reg;
    assign status       = status_reg;
    assign member_count = members_reg;
    assign range_count  = ism_pkg::RCOUNT_W'(held_reg);
    assign is_empty     = (held_reg == '0);

`ifndef ASSERT_OFF
    a_done_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ism_pkg::ST_UPD) |=> done)
        else $error("result strobe missing after update cycle");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ism_pkg::ST_UPD) |-> $onehot0(hit_vec))
        else $error("value held by more than one range");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(MAX_RANGES))
        else $error("range count above table size");

    a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ism_pkg::ST_UPD && status_next == ism_pkg::STAT_FULL)
        |=> $stable(held_reg) && $stable(members_reg))
        else $error("refused request changed the set");
`endif

endmodule

/* rtl/ism_cell.sv */
// One slot of the range table: holds one range, compares it against the
// request value and shifts with its neighbors. Depends on ism_pkg.
module ism_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ism_pkg::cell_ctrl_t            ctrl,
    input  logic [ism_pkg::VALUE_W-1:0]    value,
    input  logic [ism_pkg::VALUE_W-1:0]    prev_start,
    input  logic [ism_pkg::VALUE_W-1:0]    prev_stop,
    input  logic                           prev_used,
    input  ism_pkg::cell_flags_t           prev_flags,
    input  logic [ism_pkg::VALUE_W-1:0]    next_start,
    input  logic [ism_pkg::VALUE_W-1:0]    next_stop,
    input  logic                           next_used,
    output logic [ism_pkg::VALUE_W-1:0]    start,
    output logic [ism_pkg::VALUE_W-1:0]    stop,
    output logic                           used,
    output ism_pkg::cell_flags_t           flags
);

    logic [ism_pkg::VALUE_W-1:0] start_reg, start_next;
    logic [ism_pkg::VALUE_W-1:0] stop_reg, stop_next;
    logic                        used_reg, used_next;
    ism_pkg::cell_flags_t        flags_reg, flags_next;
    logic [ism_pkg::VALUE_W-1:0] succ_value;

    assign succ_value = value + ism_pkg::VALUE_W'(1);

    always_comb
    begin
        flags_next.hit    = used_reg && (start_reg <= value)
                            && ((stop_reg == '0) || (stop_reg > value));
        flags_next.lo     = used_reg && (value != '0) && (stop_reg == value);
        flags_next.hi     = used_reg && (value != '1) && (start_reg == succ_value);
        flags_next.gt     = used_reg && (start_reg > value);
        flags_next.hleft  = flags_next.hit && (start_reg != value);
        flags_next.hright = flags_next.hit && (stop_reg != succ_value);
    end

    always_comb
    begin
        start_next = start_reg;
        stop_next  = stop_reg;
        used_next  = used_reg;
        case (ctrl.mode)
            ism_pkg::MODE_ADD_NEW:
            begin
                if (prev_flags.gt)
                begin
                    start_next = prev_start;
                    stop_next  = prev_stop;
                    used_next  = 1'b1;
                end
                else if ((flags_reg.gt || !used_reg) && prev_used)
                begin
                    start_next = value;
                    stop_next  = succ_value;
                    used_next  = 1'b1;
                end
            end
            ism_pkg::MODE_ADD_LO:
            begin
                if (flags_reg.lo)
                    stop_next = succ_value;
            end
            ism_pkg::MODE_ADD_HI:
            begin
                if (flags_reg.hi)
                    start_next = value;
            end
            ism_pkg::MODE_ADD_BOTH:
            begin
                // lower range absorbs the upper one, the rest move down
                if (flags_reg.lo)
                    stop_next = next_stop;
                else if (flags_reg.gt)
                begin
                    start_next = next_start;
                    stop_next  = next_stop;
                    used_next  = next_used;
                end
            end
            ism_pkg::MODE_REM_DEL:
            begin
                if (flags_reg.hit || flags_reg.gt)
                begin
                    start_next = next_start;
                    stop_next  = next_stop;
                    used_next  = next_used;
                end
            end
            ism_pkg::MODE_REM_LEFT:
            begin
                if (flags_reg.hit)
                    stop_next = value;
            end
            ism_pkg::MODE_REM_RIGHT:
            begin
                if (flags_reg.hit)
                    start_next = succ_value;
            end
            ism_pkg::MODE_REM_SPLIT:
            begin
                if (flags_reg.hit)
                    stop_next = value;
                else if (prev_flags.hit)
                begin
                    start_next = succ_value;
                    stop_next  = prev_stop;
                    used_next  = 1'b1;
                end
                else if (prev_flags.gt)
                begin
                    start_next = prev_start;
                    stop_next  = prev_stop;
                    used_next  = 1'b1;
                end
            end
            default:
            begin
                start_next = start_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= 1'b0;
        else
            used_reg <= used_next;
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        stop_reg  <= stop_next;
        if (ctrl.cmp_en)
            flags_reg <= flags_next;
    end

    assign start = start_reg;
    assign stop  = stop_reg;
    assign used  = used_reg;
    assign flags = flags_reg;

endmodule
